// ===== src/rc4kt_pkg.sv =====
// shared types and constants for the rc4 keyed table stream xor block
// no dependencies; imported by rc4kt_ctrl, rc4_keyed_table_stream_xor and rc4kt_chk
`default_nettype none

package rc4kt_pkg;

  localparam int BYTE_W    = 8;
  localparam int BOX_DEPTH = 256;
  localparam int KEY_CNT_W = 9;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam logic  OP_KEY   = 1'b0;
  localparam logic  OP_DATA  = 1'b1;
  localparam byte_t IDX_LAST = 8'hff;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KSA_RD_I,
    ST_KSA_RD_J,
    ST_KSA_WR_I,
    ST_KSA_WR_J,
    ST_PRGA_RD_K,
    ST_PRGA_RD_A,
    ST_PRGA_RD_B,
    ST_PRGA_WR
  } state_t;

  typedef struct packed {
    state_t st;
    byte_t  idx;
    logic   last;
  } ctrl_t;

endpackage

`default_nettype wire

// ===== src/rc4kt_ram.sv =====
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module rc4kt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                    clk,
  input  wire logic                                    we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                        wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/rc4kt_ctrl.sv =====
// build sequencer: walks the box init, key schedule and table fill steps
// depends on rc4kt_pkg
`default_nettype none

module rc4kt_ctrl import rc4kt_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  output ctrl_t     ctrl
);

  state_t state;
  state_t state_next;
  byte_t  idx;
  logic   last;

  assign last = (idx == IDX_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      if (start) begin
        idx <= '0;
      end else if (state == ST_INIT || state == ST_KSA_WR_J || state == ST_PRGA_WR) begin
        idx <= idx + 8'd1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (start) state_next = ST_INIT;
      ST_INIT:      if (last) state_next = ST_KSA_RD_I;
      ST_KSA_RD_I:  state_next = ST_KSA_RD_J;
      ST_KSA_RD_J:  state_next = ST_KSA_WR_I;
      ST_KSA_WR_I:  state_next = ST_KSA_WR_J;
      ST_KSA_WR_J:  state_next = last ? ST_PRGA_RD_K : ST_KSA_RD_I;
      ST_PRGA_RD_K: state_next = ST_PRGA_RD_A;
      ST_PRGA_RD_A: state_next = ST_PRGA_RD_B;
      ST_PRGA_RD_B: state_next = ST_PRGA_WR;
      ST_PRGA_WR:   state_next = last ? ST_IDLE : ST_PRGA_RD_K;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl.st   = state;
    ctrl.idx  = idx;
    ctrl.last = last;
  end

endmodule

`default_nettype wire

// ===== src/rc4_keyed_table_stream_xor.sv =====
// data byte: result registered in the cycle after the request; after each data request in_ready drops
//   until the registered table read has refetched after the position advances
// key byte: does not by itself drop in_ready; key byte with key_last: builds the table in order: box init,
//   key schedule, table fill, each over all 256 box entries, serialized by the single box memory port
// reset clears control state; the table reads as zero until the first build completes
`default_nettype none

module rc4_keyed_table_stream_xor import rc4kt_pkg::*; #(
  parameter int KEY_MAX_LEN = 256
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_ready,
  input  wire logic  op,
  input  wire byte_t in_byte,
  input  wire logic  key_last,
  output logic       out_valid,
  input  wire logic  out_ready,
  output byte_t      out_byte
);

  localparam int KAW = (KEY_MAX_LEN > 1) ? $clog2(KEY_MAX_LEN) : 1;

  ctrl_t ctrl;
  logic  idle;
  logic  in_acc;
  logic  key_acc;
  logic  data_acc;
  logic  key_room;
  logic  build_start;
  logic  build_done;

  logic [KEY_CNT_W-1:0] key_count;
  logic [KEY_CNT_W-1:0] kidx;
  logic [KEY_CNT_W-1:0] kidx_inc;
  logic [KEY_CNT_W-1:0] kidx_next;
  byte_t prev;
  byte_t held;
  byte_t j_reg;
  byte_t a_reg;
  byte_t stream_pos;
  logic  table_valid;
  logic  rd_ok;

  byte_t key_rd;
  byte_t box_rd;
  byte_t tbl_rd;
  byte_t k_idx;
  byte_t add_x;
  byte_t add_y;
  byte_t add_z;
  byte_t sum;

  logic  box_we;
  byte_t box_waddr;
  byte_t box_wdata;
  byte_t box_raddr;

  assign idle        = (ctrl.st == ST_IDLE);
  assign in_ready    = idle && rd_ok && (!out_valid || out_ready);
  assign in_acc      = in_valid && in_ready;
  assign key_acc     = in_acc && (op == OP_KEY);
  assign data_acc    = in_acc && (op == OP_DATA);
  assign key_room    = (key_count < KEY_CNT_W'(KEY_MAX_LEN));
  assign build_start = key_acc && key_last;
  assign build_done  = (ctrl.st == ST_PRGA_WR) && ctrl.last;

  assign k_idx     = ctrl.idx + 8'd1;
  assign kidx_inc  = kidx + KEY_CNT_W'(1);
  assign kidx_next = (kidx_inc >= key_count) ? '0 : kidx_inc;

  rc4kt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (build_start),
    .ctrl  (ctrl)
  );

  // shared index adder, reused by the key schedule j step and the table fill a and b address steps
  always_comb begin
    add_x = '0;
    add_y = '0;
    add_z = '0;
    case (ctrl.st)
      ST_KSA_RD_J: begin
        add_x = box_rd;
        add_y = prev;
        add_z = key_rd;
      end
      ST_PRGA_RD_A: begin
        add_x = box_rd;
        add_y = k_idx;
      end
      ST_PRGA_RD_B: begin
        add_x = a_reg;
        add_y = box_rd;
      end
      default: begin
        add_x = '0;
      end
    endcase
  end

  assign sum = add_x + add_y + add_z;

  always_comb begin
    box_we    = 1'b0;
    box_waddr = ctrl.idx;
    box_wdata = ctrl.idx;
    box_raddr = ctrl.idx;
    case (ctrl.st)
      ST_INIT: begin
        box_we = 1'b1;
      end
      ST_KSA_RD_J: begin
        box_raddr = sum;
      end
      ST_KSA_WR_I: begin
        box_we    = 1'b1;
        box_wdata = box_rd;
      end
      ST_KSA_WR_J: begin
        box_we    = 1'b1;
        box_waddr = j_reg;
        box_wdata = held;
      end
      ST_PRGA_RD_K: begin
        box_raddr = k_idx;
      end
      ST_PRGA_RD_A: begin
        box_raddr = sum;
      end
      ST_PRGA_RD_B: begin
        box_raddr = sum;
      end
      default: begin
        box_we = 1'b0;
      end
    endcase
  end

  rc4kt_ram #(.WIDTH(BYTE_W), .DEPTH(KEY_MAX_LEN)) u_key_ram (
    .clk   (clk),
    .we    (key_acc && key_room),
    .waddr (key_count[KAW-1:0]),
    .wdata (in_byte),
    .raddr (kidx[KAW-1:0]),
    .rdata (key_rd)
  );

  rc4kt_ram #(.WIDTH(BYTE_W), .DEPTH(BOX_DEPTH)) u_box_ram (
    .clk   (clk),
    .we    (box_we),
    .waddr (box_waddr),
    .wdata (box_wdata),
    .raddr (box_raddr),
    .rdata (box_rd)
  );

  rc4kt_ram #(.WIDTH(BYTE_W), .DEPTH(BOX_DEPTH)) u_tbl_ram (
    .clk   (clk),
    .we    (ctrl.st == ST_PRGA_WR),
    .waddr (ctrl.idx),
    .wdata (box_rd),
    .raddr (stream_pos),
    .rdata (tbl_rd)
  );

  always_ff @(posedge clk) begin
    if (ctrl.st == ST_KSA_RD_J) begin
      held  <= box_rd;
      j_reg <= sum;
    end
    if (ctrl.st == ST_PRGA_RD_A) begin
      a_reg <= box_rd;
    end
    if (data_acc) begin
      out_byte <= in_byte ^ (table_valid ? tbl_rd : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_count   <= '0;
      kidx        <= '0;
      prev        <= '0;
      stream_pos  <= '0;
      table_valid <= 1'b0;
      rd_ok       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // the table read is registered, so its data is current in the cycle after the address settles
      rd_ok <= idle && !data_acc;

      if (build_done) begin
        key_count <= '0;
      end else if (key_acc && key_room) begin
        key_count <= key_count + KEY_CNT_W'(1);
      end

      if (build_start) begin
        kidx <= '0;
        prev <= '0;
      end else if (ctrl.st == ST_KSA_WR_J) begin
        kidx <= kidx_next;
        prev <= j_reg;
      end

      if (build_done) begin
        stream_pos  <= '0;
        table_valid <= 1'b1;
      end else if (data_acc) begin
        stream_pos <= stream_pos + 8'd1;
      end

      if (data_acc) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/rc4kt_chk.sv =====
// port level checker for rc4_keyed_table_stream_xor, bound to the top level
// depends on rc4kt_pkg
`default_nettype none

module rc4kt_chk import rc4kt_pkg::*; (
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  in_valid,
  input wire logic  in_ready,
  input wire logic  op,
  input wire byte_t in_byte,
  input wire logic  key_last,
  input wire logic  out_valid,
  input wire logic  out_ready,
  input wire byte_t out_byte
);

  a_rst_no_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte))
    else $error("pending result dropped or changed");

  a_data_gives_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_DATA) |=> out_valid)
    else $error("data request gave no result");

  a_key_no_out: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_KEY) && !out_valid |=> !out_valid)
    else $error("key request gave a result");

  a_build_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (op == OP_KEY) && key_last |=> !in_ready)
    else $error("request taken while table build starts");

endmodule

bind rc4_keyed_table_stream_xor rc4kt_chk u_rc4kt_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .op        (op),
  .in_byte   (in_byte),
  .key_last  (key_last),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_byte  (out_byte)
);

`default_nettype wire

// ===== bench/rc4_keyed_table_stream_xor_test.sv =====
// self-checking bench for rc4_keyed_table_stream_xor: directed table, then random key/data traffic
// needs rc4kt_pkg and the block itself; the expected plaintext comes from a keystream predictor here
`timescale 1ns / 100ps

module rc4_keyed_table_stream_xor_test import rc4kt_pkg::*;;

  localparam int KEY_LIMIT  = 256;
  localparam int ITEM_GOAL  = 1300;
  localparam int STALL_STOP = 20000;
  localparam int TAIL_WAIT  = 20;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  in_valid = 1'b0;
  logic  in_ready;
  logic  op = OP_KEY;
  byte_t in_byte = '0;
  logic  key_last = 1'b0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  byte_t out_byte;

  rc4_keyed_table_stream_xor #(.KEY_MAX_LEN(KEY_LIMIT)) i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .in_byte(in_byte),
    .key_last(key_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte(out_byte)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // keystream predictor state
  byte_t key_bytes [256];
  int    key_len = 0;
  byte_t sbox [256];
  byte_t ks_table [256];
  byte_t ks_pos = '0;

  byte_t plain_q [$];
  int    err_count = 0;
  int    idle_cycles = 0;
  int    n_key = 0, n_dropped = 0, n_builds = 0, n_data = 0, n_checked = 0;
  byte_t want;

  function automatic void rebuild_keystream();
    int    n, kidx, jprev, j, k, a, b;
    byte_t held;
    n = (key_len == 0) ? 1 : key_len;
    kidx = 0;
    jprev = 0;
    for (int i = 0; i < 256; i++) sbox[i] = byte_t'(i);
    for (int i = 0; i < 256; i++) begin
      held = sbox[i];
      j = (int'(held) + jprev + int'(key_bytes[kidx])) & 255;
      kidx++;
      if (kidx >= n) kidx = 0;
      sbox[i] = sbox[j];
      sbox[j] = held;
      jprev = j;
    end
    // table fill reads the box only, no swaps
    for (int i = 0; i < 256; i++) begin
      k = (i + 1) & 255;
      a = int'(sbox[k]);
      b = int'(sbox[(a + k) & 255]);
      ks_table[i] = sbox[(a + b) & 255];
    end
    key_len = 0;
    ks_pos = '0;
  endfunction

  // returns 1 when the request produces a plaintext byte
  function automatic bit apply_request(logic op_i, byte_t b, logic last, output byte_t plain);
    plain = '0;
    if (op_i == OP_KEY) begin
      if (key_len < KEY_LIMIT) begin
        key_bytes[key_len] = b;
        key_len++;
        n_key++;
      end else begin
        n_dropped++;
      end
      if (last) begin
        rebuild_keystream();
        n_builds++;
      end
      return 1'b0;
    end
    plain = b ^ ks_table[ks_pos];
    ks_pos = ks_pos + 8'd1;
    n_data++;
    return 1'b1;
  endfunction

  // mostly back to back, sometimes a short gap, now and then a long hole
  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic issue(logic op_i, byte_t b, logic last, int gap, bit typed, byte_t typed_val);
    byte_t plain;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op       <= op_i;
    in_byte  <= b;
    key_last <= last;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    if (apply_request(op_i, b, last, plain)) plain_q.push_back(typed ? typed_val : plain);
  endtask

  // receiver: runs of ready broken by stalls, with occasional long stall-free stretches
  int ready_left = 0;
  always @(posedge clk) begin
    if (ready_left == 0) begin
      if (out_ready) begin
        out_ready <= 1'b0;
        case ($urandom_range(0, 19))
          0:       ready_left = $urandom_range(20, 60);
          1, 2, 3,
          4, 5:    ready_left = $urandom_range(3, 8);
          default: ready_left = $urandom_range(0, 1);
        endcase
      end else begin
        out_ready <= 1'b1;
        ready_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                 : $urandom_range(0, 8);
      end
    end else begin
      ready_left--;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (plain_q.size() == 0) begin
          err_count++;
          $display("%0t: result with nothing expected, expected none actual %h", $time, out_byte);
        end else begin
          want = plain_q.pop_front();
          n_checked++;
          if (out_byte !== want) begin
            err_count++;
            $display("%0t: out_byte mismatch, expected %h actual %h", $time, want, out_byte);
          end
        end
      end
      if ((out_valid && out_ready) || (in_valid && in_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= STALL_STOP) begin
          $display("%0t: no request or result moved for %0d cycles, %0d results pending",
                   $time, idle_cycles, plain_q.size());
          $display("[rc4_keyed_table_stream_xor] ERROR");
          $finish;
        end
      end
    end
  end

  typedef struct {
    logic  op;
    byte_t val;
    logic  last;
    bit    typed;
    byte_t plain;
  } row_t;

  // typed rows: before any key the table is zero, so data comes back unchanged
  row_t dir_rows [18] = '{
    '{OP_DATA, 8'h00, 1'b0, 1'b1, 8'h00},
    '{OP_DATA, 8'hff, 1'b0, 1'b1, 8'hff},
    '{OP_DATA, 8'ha5, 1'b1, 1'b1, 8'ha5},  // key_last on data is ignored
    '{OP_DATA, 8'h5a, 1'b0, 1'b1, 8'h5a},
    '{OP_KEY,  8'h00, 1'b1, 1'b0, 8'h00},  // one-byte key of zero
    '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'hff, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h3c, 1'b0, 1'b0, 8'h00},
    '{OP_KEY,  8'hff, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h11, 1'b1, 1'b0, 8'h00},  // data while a key is half loaded
    '{OP_KEY,  8'h80, 1'b1, 1'b0, 8'h00},
    '{OP_DATA, 8'hff, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h01, 1'b0, 1'b0, 8'h00},
    '{OP_KEY,  8'hff, 1'b1, 1'b0, 8'h00},
    '{OP_DATA, 8'hff, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h00, 1'b0, 1'b0, 8'h00},
    '{OP_DATA, 8'h55, 1'b1, 1'b0, 8'h00}
  };

  initial begin
    int items, seq, klen, dlen;
    bit burst;
    items = 0;
    seq = 0;
    for (int i = 0; i < 256; i++) ks_table[i] = '0;

    rst <= 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[r])
      issue(dir_rows[r].op, dir_rows[r].val, dir_rows[r].last, pick_gap(1'b0),
            dir_rows[r].typed, dir_rows[r].plain);

    while (items < ITEM_GOAL) begin
      burst = ($urandom_range(0, 3) == 0);
      // a full-length key and an overlong one whose bytes past KEY_LIMIT are dropped
      if (seq == 2) klen = KEY_LIMIT;
      else if (seq == 5) klen = KEY_LIMIT + $urandom_range(1, 20);
      else begin
        case ($urandom_range(0, 49))
          0:             klen = $urandom_range(65, 300);
          1, 2, 3, 4, 5,
          6, 7:          klen = $urandom_range(17, 64);
          default:       klen = $urandom_range(1, 16);
        endcase
      end
      for (int k = 0; k < klen; k++) begin
        if ($urandom_range(0, 19) == 0) begin
          issue(OP_DATA, byte_t'($urandom), 1'($urandom), pick_gap(burst), 1'b0, '0);
          items++;
        end
        issue(OP_KEY, byte_t'($urandom), (k == klen - 1), pick_gap(burst), 1'b0, '0);
        if (k < KEY_LIMIT) items++;
      end
      dlen = $urandom_range(10, 60);
      for (int d = 0; d < dlen; d++) begin
        issue(OP_DATA, byte_t'($urandom), ($urandom_range(0, 7) == 0), pick_gap(burst),
              1'b0, '0);
        items++;
      end
      if (seq == 3) begin
        // hold the sender off until the output side has caught up
        in_valid <= 1'b0;
        @(posedge clk);
        while (plain_q.size() != 0) @(posedge clk);
      end
      seq++;
    end

    in_valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);

    $display("covered %0d key sequences: %0d key bytes stored, %0d dropped, %0d table builds",
             seq, n_key, n_dropped, n_builds);
    $display("%0d data bytes sent, %0d plaintext bytes checked, %0d mismatches",
             n_data, n_checked, err_count);
    if (err_count == 0) begin
      $display("[rc4_keyed_table_stream_xor] OK");
    end else begin
      $display("[rc4_keyed_table_stream_xor] ERROR");
    end
    $finish;
  end

endmodule
